>>> src/cpil_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cut point interval lookup package
// Field widths, function and register codes, and the command and status
// structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package cpil_pkg;

	localparam int FUNC_W     = 2;
	localparam int ATT_W      = 4;
	localparam int SLOT_W     = 5;
	localparam int COUNT_W    = 6;
	localparam int SAMPLE_W   = 32;
	localparam int INTERVAL_W = 6;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_WRITE    = 2'd0,
		FUNC_COUNT    = 2'd1,
		FUNC_CLASSIFY = 2'd2
	} func_t;

	// Register index as seen in paddr[2].
	localparam logic REG_DEGEN = 1'b0;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_LAST,
		RD_MID,
		RD_NEXT
	} rd_sel_t;

	typedef enum logic [2:0] {
		RES_ZERO,
		RES_COUNT,
		RES_MISS,
		RES_HI,
		RES_DEG
	} res_sel_t;

	typedef enum logic [1:0] {
		MODE_HOLD,
		MODE_START,
		MODE_STEP
	} mode_t;

	typedef struct packed {
		logic     capture;
		logic     wr_cut;
		logic     wr_cnt;
		rd_sel_t  rd_sel;
		mode_t    mode;
		logic     res_load;
		res_sel_t res_sel;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  missing;
		logic  empty;
		logic  above;
		logic  equal;
		logic  more;
		logic  deg_ok;
	} sts_t;

endpackage
`default_nettype wire

>>> src/cpil_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cut point interval lookup datapath
// Holds the captured item, the cut memory, the per-attribute cut counts, the
// search bounds and the result and output registers.
// ----------------------------------------------------------------------------
module cpil_datapath #(
	parameter int ATTRIBUTES  = 16,
	parameter int MAX_CUTS    = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire cpil_pkg::cmd_t                        cmd,
	input  wire logic                                  degen,
	input  wire logic [cpil_pkg::FUNC_W-1:0]           func,
	input  wire logic [cpil_pkg::ATT_W-1:0]            attribute,
	input  wire logic [cpil_pkg::SLOT_W-1:0]           cut_slot,
	input  wire logic [cpil_pkg::COUNT_W-1:0]          cut_count,
	input  wire logic signed [cpil_pkg::SAMPLE_W-1:0]  sample_value,
	input  wire logic                                  value_missing,
	output cpil_pkg::sts_t                             sts,
	output logic [cpil_pkg::INTERVAL_W-1:0]            interval
);

	localparam int ATT_SPAN  = 1 << cpil_pkg::ATT_W;
	localparam int EFF_ATT   = (ATTRIBUTES < ATT_SPAN) ? ATTRIBUTES : ATT_SPAN;
	localparam int AIW       = (EFF_ATT > 1) ? $clog2(EFF_ATT) : 1;
	localparam int CIW       = (MAX_CUTS > 1) ? $clog2(MAX_CUTS) : 1;
	localparam int NW        = $clog2(MAX_CUTS + 1);
	localparam int MEM_DEPTH = EFF_ATT * MAX_CUTS;
	localparam int MAW       = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int RW        = ((NW + 1) > cpil_pkg::INTERVAL_W) ? (NW + 1)
	                                                             : cpil_pkg::INTERVAL_W;

	logic [cpil_pkg::FUNC_W-1:0]  func_q;
	logic [cpil_pkg::ATT_W-1:0]   att_q;
	logic [cpil_pkg::SLOT_W-1:0]  slot_q;
	logic [cpil_pkg::COUNT_W-1:0] count_q;
	logic signed [VALUE_WIDTH-1:0] val_q;
	logic                         miss_q;

	logic signed [VALUE_WIDTH-1:0] val_in;
	logic signed [VALUE_WIDTH-1:0] mem [MEM_DEPTH];
	logic signed [VALUE_WIDTH-1:0] rdata_q;

	logic [NW-1:0]  cnt_q [EFF_ATT];
	logic [CIW-1:0] lo_q;
	logic [CIW-1:0] hi_q;
	logic [CIW-1:0] mid_q;
	logic [RW-1:0]  res_q;

	logic           att_ok;
	logic           slot_ok;
	logic [AIW-1:0] att_idx;
	logic [NW-1:0]  n_w;
	logic [NW-1:0]  n_dec;
	logic [CIW-1:0] nm1;
	logic           le;
	logic [CIW-1:0] nxt_lo;
	logic [CIW-1:0] nxt_hi;
	logic [CIW-1:0] mid_n;
	logic [CIW-1:0] rd_idx;
	logic [MAW-1:0] base;
	logic [MAW-1:0] rd_addr;
	logic [MAW-1:0] wr_addr;
	logic [NW-1:0]  cnt_sat;
	logic [RW-1:0]  res_d;

	// Values wider than the sample port take it as an unsigned quantity.
	generate
		if (VALUE_WIDTH <= cpil_pkg::SAMPLE_W) begin : g_val_narrow
			assign val_in = sample_value[VALUE_WIDTH-1:0];
		end else begin : g_val_wide
			assign val_in = VALUE_WIDTH'($unsigned(sample_value));
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q  <= func;
			att_q   <= attribute;
			slot_q  <= cut_slot;
			count_q <= cut_count;
			val_q   <= val_in;
			miss_q  <= value_missing;
		end
	end

	always_comb begin
		att_ok  = int'(att_q) < ATTRIBUTES;
		slot_ok = int'(slot_q) < MAX_CUTS;
		att_idx = AIW'(att_q);
		n_w     = att_ok ? cnt_q[att_idx] : '0;
		n_dec   = n_w - NW'(1);
		nm1     = CIW'(n_dec);
		le      = val_q <= rdata_q;
		cnt_sat = (int'(count_q) > MAX_CUTS) ? NW'(MAX_CUTS) : NW'(count_q);

		case (cmd.mode)
			cpil_pkg::MODE_START: begin
				nxt_lo = '0;
				nxt_hi = nm1;
			end
			cpil_pkg::MODE_STEP: begin
				nxt_lo = le ? lo_q : mid_q + CIW'(1);
				nxt_hi = le ? mid_q : hi_q;
			end
			default: begin
				nxt_lo = lo_q;
				nxt_hi = hi_q;
			end
		endcase

		mid_n = nxt_lo + ((nxt_hi - nxt_lo) >> 1);

		case (cmd.rd_sel)
			cpil_pkg::RD_LAST: rd_idx = nm1;
			cpil_pkg::RD_MID:  rd_idx = mid_n;
			cpil_pkg::RD_NEXT: rd_idx = nxt_hi + CIW'(1);
			default:           rd_idx = '0;
		endcase

		base    = MAW'(att_idx) * MAW'(MAX_CUTS);
		rd_addr = base + MAW'(rd_idx);
		wr_addr = base + MAW'(CIW'(slot_q));

		case (cmd.res_sel)
			cpil_pkg::RES_COUNT: res_d = RW'(n_w);
			cpil_pkg::RES_MISS:  res_d = RW'(n_w) + RW'(1);
			cpil_pkg::RES_HI:    res_d = RW'(nxt_hi);
			cpil_pkg::RES_DEG:   res_d = RW'(nxt_hi) + RW'(1);
			default:             res_d = '0;
		endcase

		sts.func    = cpil_pkg::func_t'(func_q);
		sts.missing = miss_q;
		sts.empty   = n_w == '0;
		sts.above   = !le;
		sts.equal   = val_q == rdata_q;
		sts.more    = nxt_hi > nxt_lo;
		sts.deg_ok  = degen && (nxt_hi < nm1);
	end

	// Cut memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.wr_cut && att_ok && slot_ok) begin
			mem[wr_addr] <= val_q;
		end
		if (cmd.rd_sel != cpil_pkg::RD_NONE) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < EFF_ATT; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (cmd.wr_cnt && att_ok) begin
			cnt_q[att_idx] <= cnt_sat;
		end
	end

	always_ff @(posedge clk) begin
		lo_q <= nxt_lo;
		hi_q <= nxt_hi;
		if (cmd.rd_sel == cpil_pkg::RD_MID) begin
			mid_q <= mid_n;
		end
		if (cmd.res_load) begin
			res_q <= res_d;
		end
		if (cmd.out_load) begin
			interval <= res_q[cpil_pkg::INTERVAL_W-1:0];
		end
	end

	// Each search step probes at or above the low bound and strictly below the high bound.
	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mode == cpil_pkg::MODE_STEP |-> (lo_q <= mid_q) && (mid_q < hi_q))
		else $error("search probe outside of its bounds");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> int'(n_w) <= MAX_CUTS)
		else $error("cut count above its maximum");

endmodule
`default_nettype wire

>>> src/cpil_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cut point interval lookup controller
// Sequences load writes and the binary search, and owns both handshakes.
// ----------------------------------------------------------------------------
module cpil_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	output logic                item_stall,
	output logic                result_valid,
	input  wire logic           result_stall,
	input  wire cpil_pkg::sts_t sts,
	output cpil_pkg::cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_LAST,
		ST_PROBE,
		ST_DEG,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign item_stall   = state_q != ST_IDLE;
	assign result_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (sts.func)
					cpil_pkg::FUNC_WRITE: begin
						cmd.wr_cut = 1'b1;
						state_d    = ST_IDLE;
					end
					cpil_pkg::FUNC_COUNT: begin
						cmd.wr_cnt = 1'b1;
						state_d    = ST_IDLE;
					end
					cpil_pkg::FUNC_CLASSIFY: begin
						if (sts.missing) begin
							cmd.res_load = 1'b1;
							cmd.res_sel  = cpil_pkg::RES_MISS;
							state_d      = ST_EMIT;
						end else if (sts.empty) begin
							cmd.res_load = 1'b1;
							cmd.res_sel  = cpil_pkg::RES_ZERO;
							state_d      = ST_EMIT;
						end else begin
							cmd.rd_sel = cpil_pkg::RD_LAST;
							state_d    = ST_LAST;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_LAST, ST_PROBE: begin
				cmd.mode = (state_q == ST_LAST) ? cpil_pkg::MODE_START : cpil_pkg::MODE_STEP;
				if (state_q == ST_LAST && sts.above) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = cpil_pkg::RES_COUNT;
					state_d      = ST_EMIT;
				end else if (sts.more) begin
					cmd.rd_sel = cpil_pkg::RD_MID;
					state_d    = ST_PROBE;
				end else if (sts.deg_ok) begin
					cmd.rd_sel = cpil_pkg::RD_NEXT;
					state_d    = ST_DEG;
				end else begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = cpil_pkg::RES_HI;
					state_d      = ST_EMIT;
				end
			end
			ST_DEG: begin
				cmd.res_load = 1'b1;
				cmd.res_sel  = sts.equal ? cpil_pkg::RES_DEG : cpil_pkg::RES_HI;
				state_d      = ST_EMIT;
			end
			ST_EMIT: begin
				// The output register takes the result once its previous beat is gone.
				if (!out_valid_q || !result_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> state_q == ST_DISPATCH)
		else $error("accepted beat not dispatched");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && result_stall))
		else $error("result register overwritten while stalled");

	a_emit_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && $past(state_q) != ST_EMIT |-> $past(cmd.res_load))
		else $error("result emitted without being computed");

endmodule
`default_nettype wire

>>> src/cut_point_interval_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cut point interval lookup
// Maps a signed fixed point value to an interval index by binary search over
// a per-attribute table of ascending cut points.
// ----------------------------------------------------------------------------
// One item is handled at a time. A load item (cut write or count write) is
// captured and then written in the dispatch state before the next item is
// accepted. A classify item with a missing value or an attribute with no cuts
// goes from dispatch straight to emit; otherwise it reads the last cut, ends
// there when the value lies above that cut, and else runs one search step per
// probe, plus a read of the following cut when the degenerate check applies.
// The cut memory has a single read port and each search step waits on one
// registered read, which sets the search length. The result sits in an output
// register, so the next item is accepted while it waits; a classify item that
// finishes while that register is still stalled waits for it. The cut table
// has no reset and needs no clearing pass; counts reset to zero.
// ----------------------------------------------------------------------------
module cut_point_interval_lookup #(
	parameter int ATTRIBUTES  = 16,
	parameter int MAX_CUTS    = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 item_valid,
	output logic                                      item_stall,
	input  wire logic [cpil_pkg::FUNC_W-1:0]          func,
	input  wire logic [cpil_pkg::ATT_W-1:0]           attribute,
	input  wire logic [cpil_pkg::SLOT_W-1:0]          cut_slot,
	input  wire logic [cpil_pkg::COUNT_W-1:0]         cut_count,
	input  wire logic signed [cpil_pkg::SAMPLE_W-1:0] sample_value,
	input  wire logic                                 value_missing,
	output logic                                      result_valid,
	input  wire logic                                 result_stall,
	output logic [cpil_pkg::INTERVAL_W-1:0]           interval,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [cpil_pkg::PADDR_W-1:0]         paddr,
	input  wire logic [cpil_pkg::PDATA_W-1:0]         pwdata,
	output logic [cpil_pkg::PDATA_W-1:0]              prdata,
	output logic                                      pready
);

	cpil_pkg::cmd_t cmd;
	cpil_pkg::sts_t sts;
	logic           degen_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == cpil_pkg::REG_DEGEN) ? cpil_pkg::PDATA_W'(degen_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degen_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && paddr[2] == cpil_pkg::REG_DEGEN) begin
			degen_q <= pwdata[0];
		end
	end

	cpil_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	cpil_datapath #(
		.ATTRIBUTES  (ATTRIBUTES),
		.MAX_CUTS    (MAX_CUTS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.degen         (degen_q),
		.func          (func),
		.attribute     (attribute),
		.cut_slot      (cut_slot),
		.cut_count     (cut_count),
		.sample_value  (sample_value),
		.value_missing (value_missing),
		.sts           (sts),
		.interval      (interval)
	);

endmodule
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cut point interval lookup testbench
// Loads per-attribute cut tables and cut counts through the item channel and
// classifies values against them. A local predictor keeps its own copy of the
// tables, the counts and the degenerate option and checks every interval
// beat. It runs a directed pass over the corner cases, then random phases
// with the sender and the receiver idling in turn.
// ----------------------------------------------------------------------------
module testbench;

	localparam int FUNC_W      = cpil_pkg::FUNC_W;
	localparam int ATT_W       = cpil_pkg::ATT_W;
	localparam int SLOT_W      = cpil_pkg::SLOT_W;
	localparam int COUNT_W     = cpil_pkg::COUNT_W;
	localparam int SAMPLE_W    = cpil_pkg::SAMPLE_W;
	localparam int INTERVAL_W  = cpil_pkg::INTERVAL_W;
	localparam int PADDR_W     = cpil_pkg::PADDR_W;
	localparam int PDATA_W     = cpil_pkg::PDATA_W;

	localparam int ATTRIBUTES  = 16;
	localparam int MAX_CUTS    = 32;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 400000;
	localparam logic [FUNC_W-1:0]  FUNC_UNUSED = 2'd3;
	localparam logic [PADDR_W-1:0] DEGEN_ADDR  = {cpil_pkg::REG_DEGEN, 2'b00};
	localparam logic signed [SAMPLE_W-1:0] VALUE_MIN = 32'sh8000_0000;
	localparam logic signed [SAMPLE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       item_valid = 1'b0;
	logic                       item_stall;
	logic [FUNC_W-1:0]          func = '0;
	logic [ATT_W-1:0]           attribute = '0;
	logic [SLOT_W-1:0]          cut_slot = '0;
	logic [COUNT_W-1:0]         cut_count = '0;
	logic signed [SAMPLE_W-1:0] sample_value = '0;
	logic                       value_missing = 1'b0;
	logic                       result_valid;
	logic                       result_stall = 1'b0;
	logic [INTERVAL_W-1:0]      interval;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [PADDR_W-1:0]         paddr = '0;
	logic [PDATA_W-1:0]         pwdata = '0;
	logic [PDATA_W-1:0]         prdata;
	logic                       pready;

	// Local copy of the block state.
	logic signed [SAMPLE_W-1:0] cut_mem [ATTRIBUTES][MAX_CUTS];
	bit [MAX_CUTS-1:0]          written_mask [ATTRIBUTES];
	int                         cut_cnt [ATTRIBUTES];
	logic                       degen_en = 1'b1;

	logic [INTERVAL_W-1:0]      pending_intervals [$];
	logic [INTERVAL_W-1:0]      expected_interval;
	int                         mismatch_count = 0;
	int                         cycle_count = 0;
	int                         send_idle_pct = 0;
	int                         recv_idle_pct = 0;

	cut_point_interval_lookup #(
		.ATTRIBUTES(ATTRIBUTES),
		.MAX_CUTS(MAX_CUTS),
		.VALUE_WIDTH(SAMPLE_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.func(func),
		.attribute(attribute),
		.cut_slot(cut_slot),
		.cut_count(cut_count),
		.sample_value(sample_value),
		.value_missing(value_missing),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.interval(interval),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_intervals.size() == 0) begin
				$display("%0t: unexpected interval beat, expected none, actual %0d",
					$time, interval);
				mismatch_count++;
			end else begin
				expected_interval = pending_intervals.pop_front();
				if (interval !== expected_interval) begin
					$display("%0t: interval mismatch, expected %0d, actual %0d",
						$time, expected_interval, interval);
					mismatch_count++;
				end
			end
		end
	end

	function automatic logic [INTERVAL_W-1:0] predict_interval(
		input logic [ATT_W-1:0] a, input logic signed [SAMPLE_W-1:0] v, input logic m);
		int n;
		int lo;
		int hi;
		int mid;
		n = cut_cnt[a];
		if (m)
			return INTERVAL_W'(n + 1);
		if (n == 0)
			return '0;
		if (v > cut_mem[a][n-1])
			return INTERVAL_W'(n);
		lo = 0;
		hi = n - 1;
		while (hi > lo) begin
			mid = lo + (hi - lo) / 2;
			if (v <= cut_mem[a][mid])
				hi = mid;
			else
				lo = mid + 1;
		end
		if (degen_en && hi < n - 1 && v == cut_mem[a][hi+1])
			hi++;
		return INTERVAL_W'(hi);
	endfunction

	// Number of leading slots written; a count above this would read an
	// entry that holds no defined value.
	function automatic int cut_prefix(input logic [ATT_W-1:0] a);
		int p;
		p = 0;
		while (p < MAX_CUTS && written_mask[a][p])
			p++;
		return p;
	endfunction

	task automatic send_item(input logic [FUNC_W-1:0] f, input logic [ATT_W-1:0] a,
		input logic [SLOT_W-1:0] s, input logic [COUNT_W-1:0] c,
		input logic signed [SAMPLE_W-1:0] v, input logic m);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		func = f;
		attribute = a;
		cut_slot = s;
		cut_count = c;
		sample_value = v;
		value_missing = m;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		case (f)
			cpil_pkg::FUNC_WRITE: begin
				cut_mem[a][s] = v;
				written_mask[a][s] = 1'b1;
			end
			cpil_pkg::FUNC_COUNT: cut_cnt[a] = (int'(c) > MAX_CUTS) ? MAX_CUTS : int'(c);
			cpil_pkg::FUNC_CLASSIFY:
				pending_intervals = {pending_intervals, predict_interval(a, v, m)};
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic load_cut(input logic [ATT_W-1:0] a, input logic [SLOT_W-1:0] s,
		input logic signed [SAMPLE_W-1:0] v);
		send_item(cpil_pkg::FUNC_WRITE, a, s, COUNT_W'($urandom), v, 1'($urandom));
	endtask

	task automatic load_count(input logic [ATT_W-1:0] a, input logic [COUNT_W-1:0] c);
		send_item(cpil_pkg::FUNC_COUNT, a, SLOT_W'($urandom), c, $urandom, 1'($urandom));
	endtask

	task automatic classify_value(input logic [ATT_W-1:0] a,
		input logic signed [SAMPLE_W-1:0] v, input logic m);
		send_item(cpil_pkg::FUNC_CLASSIFY, a, SLOT_W'($urandom), COUNT_W'($urandom), v, m);
	endtask

	task automatic send_unused();
		send_item(FUNC_UNUSED, ATT_W'($urandom), SLOT_W'($urandom), COUNT_W'($urandom),
			$urandom, 1'($urandom));
	endtask

	task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
		input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = addr;
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic check_degenerate_reg();
		logic [PDATA_W-1:0] rd;
		apb_access(1'b0, DEGEN_ADDR, '0, rd);
		if (rd !== PDATA_W'(degen_en)) begin
			$display("%0t: degenerate register mismatch, expected %0d, actual %0d",
				$time, degen_en, rd);
			mismatch_count++;
		end
	endtask

	// Waits until every interval has come back and the block has had time to
	// finish a load item, which gives no beat of its own.
	task automatic wait_idle();
		item_valid = 1'b0;
		while (pending_intervals.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_degenerate(input logic d);
		logic [PDATA_W-1:0] unused_rd;
		wait_idle();
		apb_access(1'b1, DEGEN_ADDR, PDATA_W'(d), unused_rd);
		degen_en = d;
		check_degenerate_reg();
	endtask

	task automatic test_register_reset();
		check_degenerate_reg();
	endtask

	task automatic test_directed();
		send_idle_pct = 25;
		recv_idle_pct = 25;
		// Empty tables straight after reset.
		classify_value(4'd2, 32'sd5, 1'b0);
		classify_value(4'd15, VALUE_MAX, 1'b1);
		// A table that starts at the most negative value and holds a repeated cut at zero.
		load_cut(4'd1, 5'd0, VALUE_MIN);
		load_cut(4'd1, 5'd1, 32'shFFFF_0000);
		load_cut(4'd1, 5'd2, 32'sd0);
		load_cut(4'd1, 5'd3, 32'sd0);
		load_cut(4'd1, 5'd4, 32'sh0001_0000);
		load_count(4'd1, 6'd5);
		classify_value(4'd1, VALUE_MIN, 1'b0);
		classify_value(4'd1, 32'sd0, 1'b0);
		classify_value(4'd1, VALUE_MAX, 1'b0);
		classify_value(4'd1, 32'sh0000_8000, 1'b0);
		classify_value(4'd1, -32'sd1, 1'b0);
		classify_value(4'd1, 32'sd0, 1'b1);
		send_unused();
		load_cut(4'd0, 5'd31, VALUE_MAX);
		classify_value(4'd0, VALUE_MIN, 1'b0);
		set_degenerate(1'b0);
		classify_value(4'd1, 32'sd0, 1'b0);
		// Break the ascending order and search anyway.
		load_cut(4'd1, 5'd1, VALUE_MAX);
		classify_value(4'd1, -32'sd1, 1'b0);
		load_count(4'd1, 6'd0);
		classify_value(4'd1, 32'sd5, 1'b0);
		set_degenerate(1'b1);
	endtask

	task automatic test_random(input int n_items, input int s_pct, input int r_pct);
		int sent;
		int n;
		int k;
		int idx;
		int p;
		bit narrow;
		longint v;
		logic [ATT_W-1:0] a;
		logic signed [SAMPLE_W-1:0] probe;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 80) begin
				// Fill a table with ascending cuts, enable it and probe it.
				a = ATT_W'($urandom);
				n = ($urandom_range(7) == 0) ? MAX_CUTS : int'($urandom_range(1, 8));
				narrow = 1'($urandom);
				if (narrow)
					v = longint'($signed($urandom));
				else
					v = -64'sd2147483648 + longint'($urandom_range(0, 32'h7FFF_FFFF));
				for (int i = 0; i < n; i++) begin
					if (v > 64'sd2147483647)
						v = 64'sd2147483647;
					load_cut(a, SLOT_W'(i), SAMPLE_W'(v));
					if (narrow)
						v += longint'($urandom_range(0, 3));
					else if ($urandom_range(3) != 0)
						v += longint'($urandom_range(0, 32'h0800_0000));
				end
				if (n == MAX_CUTS && $urandom_range(1) == 1)
					load_count(a, COUNT_W'($urandom_range(MAX_CUTS, 63)));
				else
					load_count(a, COUNT_W'(n));
				k = $urandom_range(2, 8);
				for (int j = 0; j < k; j++) begin
					idx = $urandom_range(0, cut_cnt[a] - 1);
					case ($urandom_range(0, 5))
						0, 1: probe = cut_mem[a][idx];
						2: probe = cut_mem[a][idx] + 32'sd1;
						3: probe = cut_mem[a][idx] - 32'sd1;
						4: probe = $urandom;
						default: probe = $urandom_range(1) ? VALUE_MAX : VALUE_MIN;
					endcase
					classify_value(a, probe, $urandom_range(9) == 0);
				end
				sent += n + 1 + k;
			end else begin
				a = ATT_W'($urandom);
				case ($urandom_range(0, 3))
					0: begin
						load_cut(a, SLOT_W'($urandom), $urandom);
						sent++;
					end
					1: begin
						p = cut_prefix(a);
						if (p == MAX_CUTS)
							load_count(a, COUNT_W'($urandom));
						else
							load_count(a, COUNT_W'($urandom_range(0, p)));
						sent++;
					end
					2: begin
						classify_value(a, $urandom, $urandom_range(7) == 0);
						sent++;
					end
					default: begin
						send_unused();
						sent++;
					end
				endcase
			end
		end
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_register_reset();
		test_directed();
		test_random(650, 8, 88);
		set_degenerate(1'b0);
		test_random(650, 88, 8);
		set_degenerate(1'b1);
		test_random(650, 0, 0);
		wait_idle();
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
